// ----- sv/assert_macros.svh -----
// Assertion macros for the max stack engine RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MSK_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define MSK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSK_ASSERT(label, clk, rstn, prop, msg)
`define MSK_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- sv/msk_pkg.sv -----
// Shared types and constants for the max stack engine.
// No dependencies; imported by msk_core and max_stack_engine.
package msk_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Operation codes of a request
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_POPMAX = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control from the handshake shell to the engine core
  typedef struct packed {
    logic start;     // request accepted this cycle
    logic out_free;  // output register can take a result
  } core_ctl_t;

  // Status from the engine core to the handshake shell
  typedef struct packed {
    logic idle;      // core can take a request
    logic done;      // result is ready to move out
  } core_sts_t;

endpackage

// ----- sv/msk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the stack entries.
module msk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/msk_core.sv -----
// Stack sequencer: count, cached top and maximum, and the scan, find and
// shift passes over the entry RAM. Depends on msk_pkg, msk_ram, assert_macros.svh.
`include "assert_macros.svh"

module msk_core #(
  parameter int DEPTH      = msk_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = msk_pkg::VALUE_BITS_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msk_pkg::core_ctl_t           ctl,
  input  msk_pkg::mode_t               mode,
  input  logic signed [VALUE_BITS-1:0] push_value,
  output msk_pkg::core_sts_t           sts,
  output logic signed [VALUE_BITS-1:0] removed_value,
  output logic signed [VALUE_BITS-1:0] top_value,
  output logic signed [VALUE_BITS-1:0] max_value,
  output logic [CW-1:0]                entry_count,
  output msk_pkg::status_t             status
);
  import msk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW-1:0] ADR_ONE  = AW'(1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [VALUE_BITS-1:0] top_r, top_nxt;
  logic signed [VALUE_BITS-1:0] max_r, max_nxt;
  logic signed [VALUE_BITS-1:0] removed_r, removed_nxt;
  status_t                 status_r, status_nxt;
  logic [AW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic                    rd_live_r, rd_live_nxt;
  logic                    pend_r, pend_nxt;
  logic [AW-1:0]           pend_ptr_r, pend_ptr_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VALUE_BITS-1:0]   ram_wdata;
  logic                    ram_re;
  logic [VALUE_BITS-1:0]   ram_rdata;
  logic signed [VALUE_BITS-1:0] rd_data;
  logic [AW-1:0]           last_addr;
  logic [AW-1:0]           cnt_m1;
  logic [AW-1:0]           cnt_m2;

  assign rd_data = ram_rdata;
  assign cnt_m1  = AW'(cnt_r - CNT_ONE);
  assign cnt_m2  = AW'(cnt_r - CNT_TWO);
  // Shift pass walks up to the old top; find and scan walk down to the bottom
  assign last_addr = (state_r == S_SHIFT) ? cnt_r[AW-1:0] : '0;

  msk_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Sequence one request through the RAM passes
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    top_nxt      = top_r;
    max_nxt      = max_r;
    removed_nxt  = removed_r;
    status_nxt   = status_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_live_nxt  = rd_live_r;
    pend_nxt     = 1'b0;
    pend_ptr_nxt = pend_ptr_r;
    ram_we       = 1'b0;
    ram_waddr    = pend_ptr_r - ADR_ONE;
    ram_wdata    = rd_data;
    ram_re       = 1'b0;

    // Issue one read per cycle while a pass is live
    if (rd_live_r) begin
      ram_re       = 1'b1;
      pend_nxt     = 1'b1;
      pend_ptr_nxt = rd_ptr_r;
      if (rd_ptr_r == last_addr) begin
        rd_live_nxt = 1'b0;
      end else if (state_r == S_SHIFT) begin
        rd_ptr_nxt = rd_ptr_r + ADR_ONE;
      end else begin
        rd_ptr_nxt = rd_ptr_r - ADR_ONE;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          removed_nxt = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_DONE;
          unique case (mode)
            MODE_PUSH: begin
              if (cnt_r == CNT_FULL) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = push_value;
                top_nxt   = push_value;
                if (cnt_r == '0 || push_value > max_r) begin
                  max_nxt = push_value;
                end
                cnt_nxt = cnt_r + CNT_ONE;
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                removed_nxt = top_r;
                cnt_nxt     = cnt_r - CNT_ONE;
                if (cnt_r != CNT_ONE) begin
                  state_nxt   = S_SCAN;
                  rd_ptr_nxt  = cnt_m2;
                  rd_live_nxt = 1'b1;
                  pend_nxt    = 1'b0;
                end
              end
            end
            MODE_POPMAX: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                removed_nxt = max_r;
                if (cnt_r == CNT_ONE) begin
                  cnt_nxt = '0;
                end else begin
                  state_nxt   = S_FIND;
                  rd_ptr_nxt  = cnt_m1;
                  rd_live_nxt = 1'b1;
                  pend_nxt    = 1'b0;
                end
              end
            end
            MODE_QUERY: begin
            end
            default: begin
            end
          endcase
        end
      end

      // Walk down from the top until the cached maximum shows up
      S_FIND: begin
        if (pend_r && rd_data == max_r) begin
          cnt_nxt     = cnt_r - CNT_ONE;
          rd_live_nxt = 1'b1;
          pend_nxt    = 1'b0;
          if (pend_ptr_r == cnt_m1) begin
            state_nxt  = S_SCAN;
            rd_ptr_nxt = cnt_m2;
          end else begin
            state_nxt  = S_SHIFT;
            rd_ptr_nxt = pend_ptr_r + ADR_ONE;
          end
        end
      end

      // Move each entry above the removed one down by one place
      S_SHIFT: begin
        if (pend_r) begin
          ram_we = 1'b1;
          if (pend_ptr_r == cnt_r[AW-1:0]) begin
            state_nxt   = S_SCAN;
            rd_ptr_nxt  = cnt_m1;
            rd_live_nxt = 1'b1;
            pend_nxt    = 1'b0;
          end
        end
      end

      // Rebuild top and maximum from the top entry down
      S_SCAN: begin
        if (pend_r) begin
          if (pend_ptr_r == cnt_m1) begin
            top_nxt = rd_data;
            max_nxt = rd_data;
          end else if (rd_data > max_r) begin
            max_nxt = rd_data;
          end
          if (pend_ptr_r == '0) begin
            state_nxt = S_DONE;
          end
        end
      end

      // Hold the result until the output register takes it
      S_DONE: begin
        if (ctl.out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      rd_live_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_live_r <= rd_live_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    max_r      <= max_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    pend_ptr_r <= pend_ptr_nxt;
  end

  assign sts.idle      = (state_r == S_IDLE);
  assign sts.done      = (state_r == S_DONE);
  assign removed_value = removed_r;
  assign top_value     = (cnt_r == '0) ? '0 : top_r;
  assign max_value     = (cnt_r == '0) ? '0 : max_r;
  assign entry_count   = cnt_r;
  assign status        = status_r;

  `MSK_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "entry count above depth")
  `MSK_ASSERT(a_full_status, clk, rst_n, (state_r == S_DONE && status_r == ST_FULL) |-> (cnt_r == CNT_FULL), "full status with room left")
  `MSK_ASSERT(a_find_hits, clk, rst_n, (state_r == S_FIND && pend_r && pend_ptr_r == '0) |-> (rd_data == max_r), "maximum not found in stack")
  `MSK_ASSERT(a_shift_room, clk, rst_n, (state_r == S_SHIFT) |-> (cnt_r < CNT_FULL && cnt_r != '0), "shift pass with bad count")

endmodule

// ----- sv/max_stack_engine.sv -----
// Max stack engine top level: request handshake, output register and core.
// Depends on msk_pkg and msk_core.
//
//   channel | direction | handshake         | payload
//   in_     | request   | in_valid/in_stall | in_mode, in_push_value
//   out_    | result    | out_valid/out_stall | removed, top, max, count, status
//
// Push, query, refusals and removals that empty the stack go from idle straight
// to done. Pop leaving N entries rescans them; pop maximum from N entries runs
// find, shift (unless the maximum is the top) and rescan, paced by the RAM read port.
// Reset empties the stack (count to zero); the entry RAM is not cleared.
// A new request is taken while a result waits in the output register; the core
// holds its next result until that register frees up.
module max_stack_engine #(
  parameter int DEPTH      = msk_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = msk_pkg::VALUE_BITS_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  msk_pkg::mode_t               in_mode,
  input  logic signed [VALUE_BITS-1:0] in_push_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_removed_value,
  output logic signed [VALUE_BITS-1:0] out_top_value,
  output logic signed [VALUE_BITS-1:0] out_max_value,
  output logic [CW-1:0]                out_entry_count_out,
  output msk_pkg::status_t             out_status
);
  import msk_pkg::*;

  core_ctl_t ctl;
  core_sts_t sts;
  logic      out_valid_r, out_valid_nxt;
  logic      load_out;

  logic signed [VALUE_BITS-1:0] core_removed;
  logic signed [VALUE_BITS-1:0] core_top;
  logic signed [VALUE_BITS-1:0] core_max;
  logic [CW-1:0]                core_count;
  status_t                      core_status;

  logic signed [VALUE_BITS-1:0] removed_r;
  logic signed [VALUE_BITS-1:0] top_r;
  logic signed [VALUE_BITS-1:0] max_r;
  logic [CW-1:0]                count_r;
  status_t                      status_r;

  // Take a request only when the core is idle
  assign in_stall     = !sts.idle;
  assign ctl.start    = in_valid && sts.idle;
  assign ctl.out_free = !out_valid_r || !out_stall;
  assign load_out     = sts.done && ctl.out_free;

  msk_core #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .mode          (in_mode),
    .push_value    (in_push_value),
    .sts           (sts),
    .removed_value (core_removed),
    .top_value     (core_top),
    .max_value     (core_max),
    .entry_count   (core_count),
    .status        (core_status)
  );

  // Hold a result until it is taken, load the next one behind it
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      removed_r <= core_removed;
      top_r     <= core_top;
      max_r     <= core_max;
      count_r   <= core_count;
      status_r  <= core_status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_removed_value   = removed_r;
  assign out_top_value       = top_r;
  assign out_max_value       = max_r;
  assign out_entry_count_out = count_r;
  assign out_status          = status_r;

endmodule
